// File: hw/rtl/wsk_pkg.sv
// ----------------------------------------------------------------------------
// Wheel speed kinematics package
// Shared widths, register indexes, chassis mode codes and the payload and
// step function of the desaturation divider.
// ----------------------------------------------------------------------------
package wsk_pkg;

   // Chassis mode codes
   localparam logic [2:0] MODE_STRAFE   = 3'd2;
   localparam logic [2:0] MODE_DIAGONAL = 3'd6;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_ROTATION_ARM = 2'd0,
      CSR_SPEED_GAIN   = 2'd1,
      CSR_SPEED_LIMIT  = 2'd2
   } csr_index_type;

   localparam int ARM_W   = 10;
   localparam int GAIN_W  = 16;
   localparam int LIM_W   = 15;
   localparam int CSR_W   = 16;
   localparam int BASE_W  = 17;   // vx +/- vy
   localparam int ROT_W   = 27;   // arm * wz
   localparam int TERM_W  = 30;   // Q12 wheel term, signed
   localparam int TMAG_W  = 29;   // magnitude of a wheel term
   localparam int PROD_W  = TMAG_W + GAIN_W;
   localparam int FRAC_W  = 20;   // Q12 * Q8
   localparam int MAG_W   = PROD_W - FRAC_W;   // 25-bit rpm magnitude
   localparam int NUM_W   = MAG_W + LIM_W;     // rpm * limit

   // Quotient of the desaturation division never exceeds the limit.
   localparam int DIV_STEPS = LIM_W;
   localparam int PRE_STAGES = 5;
   localparam int DIV_FIRST  = PRE_STAGES;
   localparam int OUT_STAGE  = DIV_FIRST + DIV_STEPS + 1;
   localparam int NSTG       = OUT_STAGE + 1;

   typedef struct packed {
      logic [MAG_W-1:0] rem_a;
      logic [MAG_W-1:0] rem_b;
      logic [LIM_W-1:0] lo_a;
      logic [LIM_W-1:0] lo_b;
      logic [LIM_W-1:0] quo_a;
      logic [LIM_W-1:0] quo_b;
      logic [MAG_W-1:0] divisor;
      logic [LIM_W-1:0] mag_a;
      logic [LIM_W-1:0] mag_b;
      logic             sign_a;
      logic             sign_b;
      logic             scaled;
   } div_type;

   // One restoring division step for both wheel pairs.
   function automatic div_type div_step(input div_type d);
      div_type          r;
      logic [MAG_W:0]   trial_a;
      logic [MAG_W:0]   trial_b;
      logic [MAG_W:0]   dvs;
      r       = d;
      dvs     = {1'b0, d.divisor};
      trial_a = {d.rem_a, d.lo_a[LIM_W-1]};
      trial_b = {d.rem_b, d.lo_b[LIM_W-1]};
      r.lo_a  = {d.lo_a[LIM_W-2:0], 1'b0};
      r.lo_b  = {d.lo_b[LIM_W-2:0], 1'b0};
      if (trial_a >= dvs) begin
         r.rem_a = MAG_W'(trial_a - dvs);
         r.quo_a = {d.quo_a[LIM_W-2:0], 1'b1};
      end else begin
         r.rem_a = trial_a[MAG_W-1:0];
         r.quo_a = {d.quo_a[LIM_W-2:0], 1'b0};
      end
      if (trial_b >= dvs) begin
         r.rem_b = MAG_W'(trial_b - dvs);
         r.quo_b = {d.quo_b[LIM_W-2:0], 1'b1};
      end else begin
         r.rem_b = trial_b[MAG_W-1:0];
         r.quo_b = {d.quo_b[LIM_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/wheel_speed_kinematics_desaturate_core.sv
// ----------------------------------------------------------------------------
// Wheel speed kinematics with desaturation
// Four-wheel mecanum inverse kinematics from a chassis command to motor rpm,
// with proportional scaling of all four wheels to a speed limit.
// ----------------------------------------------------------------------------
// The core takes one chassis command transaction per clock cycle while the
// result channel is not stalled and returns one wheel speed transaction for
// each, in order. The pipeline has five stages for the mode mix, the rotation
// product, the wheel terms, the gain product and the maximum search, one
// stage for the limit product, fifteen stages of a restoring divider that
// produces one quotient bit per stage, and the output register. Empty stages
// close up while the result channel stalls, so commands are still taken until
// every stage holds a transaction. The configuration registers should only be
// written while the pipeline is empty.
module wheel_speed_kinematics_desaturate_core (
   input  logic               clock,
   input  logic               reset,
   // Configuration
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wr_data,
   // Chassis command
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [15:0] req_vx,
   input  logic signed [15:0] req_vy,
   input  logic signed [15:0] req_wz,
   // Wheel speeds
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_wheel_front_a,
   output logic signed [15:0] rsp_wheel_front_b,
   output logic signed [15:0] rsp_wheel_rear_b,
   output logic signed [15:0] rsp_wheel_rear_a,
   output logic               rsp_was_scaled
);

   localparam int NSTG      = wsk_pkg::NSTG;
   localparam int OUT_STAGE = wsk_pkg::OUT_STAGE;
   localparam int DIV_FIRST = wsk_pkg::DIV_FIRST;
   localparam int DIV_STEPS = wsk_pkg::DIV_STEPS;
   localparam int MAG_W     = wsk_pkg::MAG_W;
   localparam int LIM_W     = wsk_pkg::LIM_W;
   localparam int TMAG_W    = wsk_pkg::TMAG_W;
   localparam int TERM_W    = wsk_pkg::TERM_W;
   localparam int ROT_W     = wsk_pkg::ROT_W;
   localparam int BASE_W    = wsk_pkg::BASE_W;
   localparam int PROD_W    = wsk_pkg::PROD_W;
   localparam int FRAC_W    = wsk_pkg::FRAC_W;
   localparam int NUM_W     = wsk_pkg::NUM_W;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [wsk_pkg::ARM_W-1:0]  arm_ff;
   logic [wsk_pkg::GAIN_W-1:0] gain_ff;
   logic [LIM_W-1:0]           limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff   <= wsk_pkg::ARM_W'(300);
         gain_ff  <= wsk_pkg::GAIN_W'(611);
         limit_ff <= LIM_W'(8000);
      end else if (csr_wr_en) begin
         case (wsk_pkg::csr_index_type'(csr_index))
            wsk_pkg::CSR_ROTATION_ARM: arm_ff   <= csr_wr_data[wsk_pkg::ARM_W-1:0];
            wsk_pkg::CSR_SPEED_GAIN:   gain_ff  <= csr_wr_data[wsk_pkg::GAIN_W-1:0];
            wsk_pkg::CSR_SPEED_LIMIT:  limit_ff <= csr_wr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Valid bits and flow control. A stage takes new data whenever it is empty
   // or the stage after it is moving, so bubbles are squeezed out while the
   // result channel is stalled.
   // ------------------------------------------------------------------------
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] ready;

   assign ready[OUT_STAGE] = !v_ff[OUT_STAGE] || !rsp_stall;

   genvar gi;
   generate
      for (gi = 0; gi < OUT_STAGE; gi++) begin : g_ready
         assign ready[gi] = !v_ff[gi] || ready[gi+1];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ready[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (ready[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !ready[0];

   // ------------------------------------------------------------------------
   // Stage 0: mode mix. Wheels 0 and 3 take +A, wheels 1 and 2 take -A.
   // ------------------------------------------------------------------------
   logic signed [BASE_W-1:0] base0_in, base0_ff;
   logic signed [15:0]       wz0_ff;
   logic signed [BASE_W-1:0] vx_ext, vy_ext;

   assign vx_ext = {req_vx[15], req_vx};
   assign vy_ext = {req_vy[15], req_vy};

   always_comb begin
      case (req_mode)
         wsk_pkg::MODE_STRAFE:   base0_in = vy_ext + vx_ext;
         wsk_pkg::MODE_DIAGONAL: base0_in = vx_ext;
         default:                base0_in = vx_ext - vy_ext;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         base0_ff <= base0_in;
         wz0_ff   <= req_wz;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: rotation product, arm (mm) times yaw rate (Q4.12).
   // ------------------------------------------------------------------------
   logic signed [ROT_W-1:0]  rot1_in, rot1_ff;
   logic signed [BASE_W-1:0] base1_ff;

   assign rot1_in = ROT_W'($signed({1'b0, arm_ff})) * ROT_W'(wz0_ff);

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         rot1_ff  <= rot1_in;
         base1_ff <= base0_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: the two distinct wheel terms in Q12 mm/s, held as sign and
   // magnitude so that the later divisions truncate toward zero.
   // ------------------------------------------------------------------------
   logic [TERM_W-1:0] base_q12, rot_ext, term_a, term_b, neg_a, neg_b;
   logic [TMAG_W-1:0] tmag2_a_ff, tmag2_b_ff;
   logic              tsign2_a_ff, tsign2_b_ff;

   assign base_q12 = {base1_ff[BASE_W-1], base1_ff, 12'b0};
   assign rot_ext  = {{(TERM_W-ROT_W){rot1_ff[ROT_W-1]}}, rot1_ff};
   assign term_a   = base_q12 - rot_ext;
   assign term_b   = TERM_W'(0) - base_q12 - rot_ext;
   assign neg_a    = TERM_W'(0) - term_a;
   assign neg_b    = TERM_W'(0) - term_b;

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         tsign2_a_ff <= term_a[TERM_W-1];
         tsign2_b_ff <= term_b[TERM_W-1];
         tmag2_a_ff  <= term_a[TERM_W-1] ? neg_a[TMAG_W-1:0] : term_a[TMAG_W-1:0];
         tmag2_b_ff  <= term_b[TERM_W-1] ? neg_b[TMAG_W-1:0] : term_b[TMAG_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: gain product, Q12 times Q8, keeping the integer rpm.
   // ------------------------------------------------------------------------
   logic [PROD_W-1:0] prod_a, prod_b;
   logic [MAG_W-1:0]  mag3_a_ff, mag3_b_ff;
   logic              sign3_a_ff, sign3_b_ff;

   assign prod_a = PROD_W'(tmag2_a_ff) * PROD_W'(gain_ff);
   assign prod_b = PROD_W'(tmag2_b_ff) * PROD_W'(gain_ff);

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         mag3_a_ff  <= prod_a[PROD_W-1:FRAC_W];
         mag3_b_ff  <= prod_b[PROD_W-1:FRAC_W];
         sign3_a_ff <= tsign2_a_ff;
         sign3_b_ff <= tsign2_b_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: largest magnitude and the decision to scale. A magnitude equal
   // to the limit is left alone.
   // ------------------------------------------------------------------------
   logic [MAG_W-1:0] max_in;
   logic [MAG_W-1:0] mag4_a_ff, mag4_b_ff, max4_ff;
   logic             sign4_a_ff, sign4_b_ff, scaled4_ff;

   assign max_in = (mag3_a_ff > mag3_b_ff) ? mag3_a_ff : mag3_b_ff;

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         mag4_a_ff  <= mag3_a_ff;
         mag4_b_ff  <= mag3_b_ff;
         max4_ff    <= max_in;
         sign4_a_ff <= sign3_a_ff;
         sign4_b_ff <= sign3_b_ff;
         scaled4_ff <= max_in > MAG_W'(limit_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Divider entry: numerator rpm * limit. Its quotient by the maximum fits in
   // the limit width, so the upper bits start as the partial remainder.
   // ------------------------------------------------------------------------
   wsk_pkg::div_type div_ff [DIV_STEPS+1];
   wsk_pkg::div_type div0_in;
   logic [NUM_W-1:0] num_a, num_b;

   assign num_a = NUM_W'(mag4_a_ff) * NUM_W'(limit_ff);
   assign num_b = NUM_W'(mag4_b_ff) * NUM_W'(limit_ff);

   always_comb begin
      div0_in.rem_a   = num_a[NUM_W-1:LIM_W];
      div0_in.rem_b   = num_b[NUM_W-1:LIM_W];
      div0_in.lo_a    = num_a[LIM_W-1:0];
      div0_in.lo_b    = num_b[LIM_W-1:0];
      div0_in.quo_a   = '0;
      div0_in.quo_b   = '0;
      div0_in.divisor = max4_ff;
      div0_in.mag_a   = mag4_a_ff[LIM_W-1:0];
      div0_in.mag_b   = mag4_b_ff[LIM_W-1:0];
      div0_in.sign_a  = sign4_a_ff;
      div0_in.sign_b  = sign4_b_ff;
      div0_in.scaled  = scaled4_ff;
   end

   always_ff @(posedge clock) begin
      if (ready[DIV_FIRST]) begin
         div_ff[0] <= div0_in;
      end
   end

   // One quotient bit per stage for both wheel pairs.
   generate
      for (gi = 1; gi <= DIV_STEPS; gi++) begin : g_div
         always_ff @(posedge clock) begin
            if (ready[DIV_FIRST+gi]) begin
               div_ff[gi] <= wsk_pkg::div_step(div_ff[gi-1]);
            end
         end
      end
   endgenerate

   // ------------------------------------------------------------------------
   // Output register. Without scaling every magnitude is within the limit
   // and so fits the limit width.
   // ------------------------------------------------------------------------
   logic [LIM_W-1:0]   val_a, val_b;
   logic signed [15:0] res_a, res_b;
   logic signed [15:0] out_a_ff, out_b_ff;
   logic               out_scaled_ff;

   assign val_a = div_ff[DIV_STEPS].scaled ? div_ff[DIV_STEPS].quo_a : div_ff[DIV_STEPS].mag_a;
   assign val_b = div_ff[DIV_STEPS].scaled ? div_ff[DIV_STEPS].quo_b : div_ff[DIV_STEPS].mag_b;
   assign res_a = div_ff[DIV_STEPS].sign_a ? (16'sd0 - $signed({1'b0, val_a}))
                                           : $signed({1'b0, val_a});
   assign res_b = div_ff[DIV_STEPS].sign_b ? (16'sd0 - $signed({1'b0, val_b}))
                                           : $signed({1'b0, val_b});

   always_ff @(posedge clock) begin
      if (ready[OUT_STAGE]) begin
         out_a_ff      <= res_a;
         out_b_ff      <= res_b;
         out_scaled_ff <= div_ff[DIV_STEPS].scaled;
      end
   end

   assign rsp_valid         = v_ff[OUT_STAGE];
   assign rsp_wheel_front_a = out_a_ff;
   assign rsp_wheel_rear_a  = out_a_ff;
   assign rsp_wheel_front_b = out_b_ff;
   assign rsp_wheel_rear_b  = out_b_ff;
   assign rsp_was_scaled    = out_scaled_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // The command channel is only stalled when every stage holds a transaction.
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff))
      else $error("command stalled while a pipeline stage was empty");

   // The restoring divider keeps its remainders below the divisor.
   a_div_remainder : assert property (@(posedge clock) disable iff (reset)
      (v_ff[OUT_STAGE-1] && div_ff[DIV_STEPS].scaled) |->
         (div_ff[DIV_STEPS].rem_a < div_ff[DIV_STEPS].divisor) &&
         (div_ff[DIV_STEPS].rem_b < div_ff[DIV_STEPS].divisor))
      else $error("divider remainder not below divisor");

   // A transaction leaving the divider while the output moves is presented next.
   a_out_load : assert property (@(posedge clock) disable iff (reset)
      (v_ff[OUT_STAGE-1] && ready[OUT_STAGE]) |=> rsp_valid)
      else $error("finished transaction lost at the output register");

endmodule
